/* sv/cht_pkg.sv */
// Shared types, codes and defaults for the coalesced hash table.
`default_nettype none
package cht_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 64;

  // Field widths fixed by the request and response formats
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  // Request codes
  localparam logic [1:0] REQ_GET    = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cht_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [VAL_W-1:0] value_out;
  } cht_resp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_MOD_FIX,
    S_WALK,
    S_PROBE,
    S_SET_WR,
    S_SET_LINK,
    S_REM_CLR,
    S_REM_LINK,
    S_FINISH
  } cht_state_t;

endpackage
`default_nettype wire

/* sv/coalesced_hash_table.sv */
// Coalesced hash table: request sequencer, entry memories and result register.
//
// Keeps TABLE_ENTRIES entries of key, value and chain links; a zero value marks
// a free entry. Each request (get, set, remove) is taken when the block is idle
// and produces one response. After reset the block runs a clearing pass over all
// TABLE_ENTRIES entries with in_stall high. A request reads one entry per chain
// step followed and per slot probed, as the memories share one registered read
// port giving one entry per cycle; set writes the entry and, if the free slot is
// not the chain tail, links it behind the tail; remove clears it and splices its
// neighbours. If TABLE_ENTRIES is not a power of two, S_MOD and S_MOD_FIX find
// the home slot by a reciprocal multiply and one correcting subtract. A finished
// response waits in the output register while the next request is taken.
`default_nettype none
module coalesced_hash_table #(
  parameter int TABLE_ENTRIES = cht_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cht_pkg::cht_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cht_pkg::cht_resp_t     out_data
);
  import cht_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LW = $clog2(TABLE_ENTRIES + 1);
  localparam bit POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [LW-1:0] STEP_MAX = LW'(TABLE_ENTRIES);
  localparam logic [IW:0]   MODULUS  = (IW+1)'(TABLE_ENTRIES);
  localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_ENTRIES));

  // Entry memories
  logic [KEY_W-1:0] key_mem_r [TABLE_ENTRIES];
  logic [VAL_W-1:0] val_mem_r [TABLE_ENTRIES];
  logic [LW-1:0]    nxt_mem_r [TABLE_ENTRIES];
  logic [LW-1:0]    prv_mem_r [TABLE_ENTRIES];

  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;
  logic [LW-1:0]    nxt_rd_r;
  logic [LW-1:0]    prv_rd_r;

  logic             key_we, val_we, nxt_we, prv_we;
  logic [IW-1:0]    key_wa, val_wa, nxt_wa, prv_wa;
  logic [KEY_W-1:0] key_wd;
  logic [VAL_W-1:0] val_wd;
  logic [LW-1:0]    nxt_wd, prv_wd;
  logic [IW-1:0]    rd_addr;

  // Sequencer state
  cht_state_t       state_r, state_nxt;
  cht_req_t         req_r, req_nxt;
  cht_resp_t        res_r, res_nxt;
  cht_resp_t        out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;
  logic [LW-1:0]    steps_r, steps_nxt;
  logic [LW-1:0]    count_r, count_nxt;
  logic [LW-1:0]    lnk_p_r, lnk_p_nxt;
  logic [LW-1:0]    lnk_n_r, lnk_n_nxt;
  logic [KEY_W-1:0] modk_r, modk_nxt;

  logic [2*KEY_W-1:0] mod_prod;
  logic [IW:0]      mod_qn;
  logic [IW:0]      mod_diff;
  logic [IW-1:0]    mod_rem;
  logic [IW-1:0]    cur_inc;
  logic             key_hit;
  logic             entry_hit;
  logic             walk_more;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write ports and one shared registered read port
  always_ff @(posedge clk) begin
    if (key_we) key_mem_r[key_wa] <= key_wd;
    if (val_we) val_mem_r[val_wa] <= val_wd;
    if (nxt_we) nxt_mem_r[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem_r[prv_wa] <= prv_wd;
    key_rd_r <= key_mem_r[rd_addr];
    val_rd_r <= val_mem_r[rd_addr];
    nxt_rd_r <= nxt_mem_r[rd_addr];
    prv_rd_r <= prv_mem_r[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    cur_r      <= cur_nxt;
    tail_r     <= tail_nxt;
    steps_r    <= steps_nxt;
    lnk_p_r    <= lnk_p_nxt;
    lnk_n_r    <= lnk_n_nxt;
    modk_r     <= modk_nxt;
  end

  // Home slot: quotient estimate by reciprocal, then one correcting subtract
  assign mod_prod  = {{KEY_W{1'b0}}, req_r.key} * {{KEY_W{1'b0}}, RECIP};
  assign mod_qn    = modk_r[IW:0] * MODULUS;
  assign mod_diff  = req_r.key[IW:0] - mod_qn;
  assign mod_rem   = (mod_diff >= MODULUS) ? IW'(mod_diff - MODULUS) : IW'(mod_diff);

  // Shared helpers: slot increment, entry compare
  assign cur_inc   = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;
  assign key_hit   = (key_rd_r == req_r.key);
  assign entry_hit = key_hit && (val_rd_r != '0);
  assign walk_more = (nxt_rd_r != '0) && !key_hit && (steps_r != STEP_MAX);

  // Next state, datapath and memory writes
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    cur_nxt       = cur_r;
    tail_nxt      = tail_r;
    clr_nxt       = clr_r;
    steps_nxt     = steps_r;
    count_nxt     = count_r;
    lnk_p_nxt     = lnk_p_r;
    lnk_n_nxt     = lnk_n_r;
    modk_nxt      = modk_r;

    key_we = 1'b0;  key_wa = cur_r;  key_wd = '0;
    val_we = 1'b0;  val_wa = cur_r;  val_wd = '0;
    nxt_we = 1'b0;  nxt_wa = cur_r;  nxt_wd = '0;
    prv_we = 1'b0;  prv_wa = cur_r;  prv_wd = '0;

    // Drop the response once the consumer takes it
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Zero one entry per cycle
        key_we = 1'b1;  key_wa = clr_r;
        val_we = 1'b1;  val_wa = clr_r;
        nxt_we = 1'b1;  nxt_wa = clr_r;
        prv_we = 1'b1;  prv_wa = clr_r;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_nxt   = '{status: STAT_OK, found: 1'b0, value_out: '0};
        steps_nxt = '0;
        if ((req_r.req_type != REQ_GET) && (req_r.req_type != REQ_SET) &&
            (req_r.req_type != REQ_REMOVE)) begin
          state_nxt = S_FINISH;
        end else if ((req_r.req_type == REQ_SET) && (req_r.value == '0)) begin
          state_nxt = S_FINISH;
        end else if ((req_r.req_type == REQ_SET) && (count_r >= STEP_MAX)) begin
          res_nxt.status = STAT_FULL;
          state_nxt      = S_FINISH;
        end else if (POW2) begin
          cur_nxt   = req_r.key[IW-1:0];
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_MOD;
        end
      end

      S_MOD: begin
        // Hold the quotient estimate of the key
        modk_nxt  = mod_prod[2*KEY_W-1:KEY_W];
        state_nxt = S_MOD_FIX;
      end

      S_MOD_FIX: begin
        cur_nxt   = mod_rem;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        if (req_r.req_type == REQ_SET) begin
          // Follow the chain to its tail
          if (nxt_rd_r != '0) begin
            if (steps_r == STEP_MAX) begin
              res_nxt.status = STAT_FULL;
              state_nxt      = S_FINISH;
            end else begin
              cur_nxt   = IW'(nxt_rd_r - 1'b1);
              steps_nxt = steps_r + 1'b1;
            end
          end else begin
            tail_nxt  = cur_r;
            steps_nxt = '0;
            state_nxt = S_PROBE;
          end
        end else if (walk_more) begin
          cur_nxt   = IW'(nxt_rd_r - 1'b1);
          steps_nxt = steps_r + 1'b1;
        end else if (!entry_hit) begin
          res_nxt.status = STAT_MISS;
          state_nxt      = S_FINISH;
        end else if (req_r.req_type == REQ_GET) begin
          res_nxt.found     = 1'b1;
          res_nxt.value_out = val_rd_r;
          state_nxt         = S_FINISH;
        end else begin
          lnk_p_nxt = prv_rd_r;
          lnk_n_nxt = nxt_rd_r;
          state_nxt = S_REM_CLR;
        end
      end

      S_PROBE: begin
        // Step linearly from the tail to a free slot
        if (val_rd_r != '0) begin
          if (steps_r == STEP_MAX) begin
            res_nxt.status = STAT_FULL;
            state_nxt      = S_FINISH;
          end else begin
            cur_nxt   = cur_inc;
            steps_nxt = steps_r + 1'b1;
          end
        end else begin
          state_nxt = S_SET_WR;
        end
      end

      S_SET_WR: begin
        key_we = 1'b1;  key_wd = req_r.key;
        val_we = 1'b1;  val_wd = req_r.value;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (cur_r != tail_r) begin
          prv_wd    = LW'(tail_r) + 1'b1;
          state_nxt = S_SET_LINK;
        end else begin
          state_nxt = S_FINISH;
        end
        count_nxt = count_r + 1'b1;
      end

      S_SET_LINK: begin
        // Hook the new entry behind the tail
        nxt_we    = 1'b1;
        nxt_wa    = tail_r;
        nxt_wd    = LW'(cur_r) + 1'b1;
        state_nxt = S_FINISH;
      end

      S_REM_CLR: begin
        key_we = 1'b1;
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (count_r != '0) count_nxt = count_r - 1'b1;
        res_nxt.found = 1'b1;
        state_nxt     = S_REM_LINK;
      end

      S_REM_LINK: begin
        // Splice the neighbors together
        if (lnk_p_r != '0) begin
          nxt_we = 1'b1;
          nxt_wa = IW'(lnk_p_r - 1'b1);
          nxt_wd = lnk_n_r;
        end
        if (lnk_n_r != '0) begin
          prv_we = 1'b1;
          prv_wa = IW'(lnk_n_r - 1'b1);
          prv_wd = lnk_p_r;
        end
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        // Load the response once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rd_addr = cur_nxt;
  end

endmodule
`default_nettype wire
